/* rtl/pcs_pkg.sv */
// ----------------------------------------------------------------------------
// pcs_pkg
// shared types and constants of the pitch cascade stabilizer
// ----------------------------------------------------------------------------
package pcs_pkg;

  localparam int unsigned HalfW = 16;
  localparam int unsigned WordW = 32;
  localparam int unsigned CntW  = $clog2(HalfW);

  localparam logic [HalfW-1:0] LeadDecay = 16'd59297;
  localparam logic [HalfW-1:0] LeadTap   = 16'd6239;

  typedef enum logic [2:0] {
    REG_OUTER_GAIN   = 3'd0,
    REG_FF_GAIN      = 3'd1,
    REG_RATE_GAIN    = 3'd2,
    REG_LEAD_GAIN    = 3'd3,
    REG_STAB_ENABLE  = 3'd4,
    REG_LOADING_TRIM = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic             load;
    logic             sub;
    logic [HalfW-1:0] mcand;
    logic [HalfW-1:0] mplier;
    logic [WordW-1:0] base;
  } mac_cmd_t;

  typedef struct packed {
    logic             done;
    logic [WordW-1:0] result;
  } mac_rsp_t;

endpackage

/* rtl/pitch_cascade_stabilizer_unit.sv */
// ----------------------------------------------------------------------------
// pitch_cascade_stabilizer_unit
// cascaded pd pitch controller with a first-order lead filter on rate error
// ----------------------------------------------------------------------------
// channel   direction  fields (lsb first)
// s_axis    in         tdata: tilt_error, desired_rate, rate_error; tuser: feedback_on
// m_axis    out        tdata: drive, outer_term
// cfg       in         index 0..5 selects the register, data carries its value
//
// each beat is worked out by the bit-serial multiplier, which is shared by
// all six products in turn
// the lead accumulator resets to zero and the stabilize enable to one
// a new beat is taken while a finished result still waits on m_axis
// ----------------------------------------------------------------------------
module pitch_cascade_stabilizer_unit
  import pcs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // tilt_error, desired_rate, rate_error
  input  logic        s_axis_tuser,   // feedback_on
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // drive, outer_term, zero fill
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_MUL  = 3'b010,
    ST_FIN  = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic [2:0] ph_q, ph_d;

  logic [15:0] outer_gain_q, ff_gain_q, rate_gain_q, lead_gain_q;
  logic        stab_en_q;
  logic [15:0] trim_q;

  logic [15:0] drate_q, rerr_q;
  logic        fb_q;
  logic [31:0] lead_q, lead_d;
  logic [31:0] g_q, g_d;
  logic [15:0] outer_hi_q, outer_hi_d;
  logic [15:0] rate_hi_q, rate_hi_d;
  logic [15:0] lead_hi_q, lead_hi_d;

  logic        out_valid_q, out_valid_d;
  logic [17:0] drive_q, drive_d;
  logic [16:0] outer_q, outer_d;

  mac_cmd_t mac_cmd;
  mac_rsp_t mac_rsp;
  logic     in_acc;
  logic     out_free;
  logic [16:0] outer_part;
  logic [17:0] rate_part, lead_part;

  pcs_smac u_smac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (mac_cmd),
    .rsp_o  (mac_rsp)
  );

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  always_comb begin
    state_d    = state_q;
    ph_d       = ph_q;
    lead_d     = lead_q;
    g_d        = g_q;
    outer_hi_d = outer_hi_q;
    rate_hi_d  = rate_hi_q;
    lead_hi_d  = lead_hi_q;
    mac_cmd    = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          mac_cmd.load   = 1'b1;
          mac_cmd.mcand  = s_axis_tdata[15:0];
          mac_cmd.mplier = outer_gain_q;
          ph_d           = 3'd0;
          state_d        = ST_MUL;
        end
      end
      ST_MUL: begin
        if (mac_rsp.done) begin
          ph_d = ph_q + 1'b1;
          case (ph_q)
            3'd0: begin
              mac_cmd.load   = 1'b1;
              mac_cmd.sub    = 1'b1;
              mac_cmd.mcand  = drate_q;
              mac_cmd.mplier = ff_gain_q;
              mac_cmd.base   = mac_rsp.result;
            end
            3'd1: begin
              outer_hi_d     = mac_rsp.result[31:16];
              mac_cmd.load   = 1'b1;
              mac_cmd.mcand  = rerr_q;
              mac_cmd.mplier = rate_gain_q;
            end
            3'd2: begin
              rate_hi_d      = mac_rsp.result[31:16];
              mac_cmd.load   = 1'b1;
              mac_cmd.mcand  = rerr_q;
              mac_cmd.mplier = lead_gain_q;
            end
            3'd3: begin
              g_d            = mac_rsp.result;
              mac_cmd.load   = 1'b1;
              mac_cmd.mcand  = lead_q[31:16];
              mac_cmd.mplier = LeadDecay;
              mac_cmd.base   = mac_rsp.result;
            end
            3'd4: begin
              if (fb_q) begin
                lead_d = mac_rsp.result;
              end
              mac_cmd.load   = 1'b1;
              mac_cmd.sub    = 1'b1;
              mac_cmd.mcand  = mac_rsp.result[31:16];
              mac_cmd.mplier = LeadTap;
              mac_cmd.base   = g_q;
            end
            default: begin
              lead_hi_d = mac_rsp.result[31:16];
              state_d   = ST_FIN;
            end
          endcase
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign outer_part = ((stab_en_q && fb_q) ? {outer_hi_q[15], outer_hi_q} : 17'd0)
                    + {trim_q[15], trim_q};
  assign rate_part  = fb_q ? {{2{rate_hi_q[15]}}, rate_hi_q} : 18'd0;
  assign lead_part  = fb_q ? {{2{lead_hi_q[15]}}, lead_hi_q} : 18'd0;

  always_comb begin
    out_valid_d = out_valid_q;
    drive_d     = drive_q;
    outer_d     = outer_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (state_q == ST_FIN && out_free) begin
      out_valid_d = 1'b1;
      outer_d     = outer_part;
      drive_d     = {outer_part[16], outer_part} + rate_part + lead_part;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      ph_q         <= '0;
      out_valid_q  <= 1'b0;
      lead_q       <= '0;
      outer_gain_q <= '0;
      ff_gain_q    <= '0;
      rate_gain_q  <= '0;
      lead_gain_q  <= '0;
      stab_en_q    <= 1'b1;
      trim_q       <= '0;
    end else begin
      state_q     <= state_d;
      ph_q        <= ph_d;
      out_valid_q <= out_valid_d;
      lead_q      <= lead_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_OUTER_GAIN:   outer_gain_q <= cfg_data_i;
          REG_FF_GAIN:      ff_gain_q    <= cfg_data_i;
          REG_RATE_GAIN:    rate_gain_q  <= cfg_data_i;
          REG_LEAD_GAIN:    lead_gain_q  <= cfg_data_i;
          REG_STAB_ENABLE:  stab_en_q    <= cfg_data_i[0];
          REG_LOADING_TRIM: trim_q       <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      drate_q <= s_axis_tdata[31:16];
      rerr_q  <= s_axis_tdata[47:32];
      fb_q    <= s_axis_tuser;
    end
    g_q        <= g_d;
    outer_hi_q <= outer_hi_d;
    rate_hi_q  <= rate_hi_d;
    lead_hi_q  <= lead_hi_d;
    drive_q    <= drive_d;
    outer_q    <= outer_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, outer_q, drive_q};

endmodule

/* rtl/pcs_smac.sv */
// ----------------------------------------------------------------------------
// pcs_smac
// serial multiply-accumulate: base +/- signed x unsigned, one multiplier bit
// per cycle, wrapped to 32 bits
// ----------------------------------------------------------------------------
module pcs_smac
  import pcs_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mac_cmd_t cmd_i,
  output mac_rsp_t rsp_o
);

  logic             run_q, run_d;
  logic             sub_q, sub_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [WordW-1:0] acc_q, acc_d;
  logic [WordW-1:0] mcand_q, mcand_d;
  logic [HalfW-1:0] mplier_q, mplier_d;
  logic [WordW-1:0] addend;
  logic [WordW-1:0] acc_step;
  logic             last;

  assign addend   = mplier_q[0] ? mcand_q : '0;
  assign acc_step = sub_q ? acc_q - addend : acc_q + addend;
  assign last     = run_q && (cnt_q == CntW'(HalfW - 1));

  always_comb begin
    run_d    = run_q;
    sub_d    = sub_q;
    cnt_d    = cnt_q;
    acc_d    = acc_q;
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    if (cmd_i.load) begin
      run_d    = 1'b1;
      sub_d    = cmd_i.sub;
      cnt_d    = '0;
      acc_d    = cmd_i.base;
      mcand_d  = {{(WordW-HalfW){cmd_i.mcand[HalfW-1]}}, cmd_i.mcand};
      mplier_d = cmd_i.mplier;
    end else if (run_q) begin
      acc_d    = acc_step;
      mcand_d  = {mcand_q[WordW-2:0], 1'b0};
      mplier_d = {1'b0, mplier_q[HalfW-1:1]};
      cnt_d    = cnt_q + 1'b1;
      if (last) begin
        run_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      run_q <= run_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sub_q    <= sub_d;
    acc_q    <= acc_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
  end

  assign rsp_o.done   = last;
  assign rsp_o.result = acc_step;

endmodule

/* tb/pitch_cascade_stabilizer_unit_test.sv */
// ----------------------------------------------------------------------------
// pitch_cascade_stabilizer_unit_test
// self-checking bench for the cascaded pitch controller. Control ticks are
// streamed in bursts while the result side stalls on its own pattern. A
// behavioural copy of the controller, including the lead filter accumulator,
// works out drive and outer term for every accepted tick. Each result beat is
// then compared field by field against the oldest pending prediction.
// Directed ticks cover the reset state, the field extremes, the outer loop off,
// feedback off and ignored register indexes. Random phases follow, each under
// its own gain set.
// ----------------------------------------------------------------------------
module pitch_cascade_stabilizer_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import pcs_pkg::*;

  localparam int unsigned CLK_PERIOD     = 10;
  localparam int unsigned RST_CYCLES     = 12;
  localparam int unsigned CYCLE_LIMIT    = 2_000_000;
  localparam int unsigned DRAIN_CYCLES   = 250;
  localparam int unsigned RANDOM_PHASES  = 5;
  localparam int unsigned TICKS_PER_PHASE = 250;

  localparam logic [2:0] CFG_SPARE_LO = 3'd6;
  localparam logic [2:0] CFG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [16:0] outer;
    logic [17:0] drive;
  } pitch_result_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata  = '0;   // tilt_error, desired_rate, rate_error
  logic        s_axis_tuser  = 1'b0; // feedback_on
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;         // drive, outer_term, zero fill
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i   = '0;
  logic [15:0] cfg_data_i    = '0;

  // controller copy
  logic [15:0] gain_outer_m = '0;
  logic [15:0] gain_ff_m    = '0;
  logic [15:0] gain_rate_m  = '0;
  logic [15:0] gain_lead_m  = '0;
  logic        stab_en_m    = 1'b1;
  logic [15:0] trim_m       = '0;
  logic [31:0] lead_acc_m   = '0;

  pitch_result_t pitch_result_q[$];
  int unsigned   fail_cnt    = 0;
  int unsigned   cycle_cnt   = 0;
  int unsigned   burst_left  = 0;
  int unsigned   gap_max     = 4;
  int unsigned   stall_max   = 6;
  int unsigned   ready_left  = 0;
  bit            rx_always   = 1'b0;

  pitch_cascade_stabilizer_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic logic [31:0] sext16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  // signed by unsigned 16-bit product, wrapped to 32 bits
  function automatic logic [31:0] wrap_mul(input logic [15:0] s, input logic [15:0] u);
    logic [31:0] a;
    a = sext16(s);
    return a * {16'h0000, u};
  endfunction

  function automatic pitch_result_t predict_pitch_tick(input logic [15:0] tilt,
                                                       input logic [15:0] drate,
                                                       input logic [15:0] rerr,
                                                       input logic        fb);
    logic [31:0]   outer_hi;
    logic [31:0]   rate_hi;
    logic [31:0]   lead_hi;
    logic [31:0]   outer;
    logic [31:0]   drive;
    logic [31:0]   g;
    logic [31:0]   rate_p;
    pitch_result_t r;
    outer_hi = '0;
    rate_hi  = '0;
    lead_hi  = '0;
    if (stab_en_m && fb) begin
      g = wrap_mul(tilt, gain_outer_m) - wrap_mul(drate, gain_ff_m);
      outer_hi = sext16(g[31:16]);
    end
    outer = outer_hi + sext16(trim_m);
    if (fb) begin
      g = wrap_mul(rerr, gain_lead_m);
      lead_acc_m = wrap_mul(lead_acc_m[31:16], LeadDecay);
      lead_acc_m = lead_acc_m + g;
      g = g - wrap_mul(lead_acc_m[31:16], LeadTap);
      lead_hi = sext16(g[31:16]);
      rate_p = wrap_mul(rerr, gain_rate_m);
      rate_hi = sext16(rate_p[31:16]);
    end
    drive   = outer + rate_hi + lead_hi;
    r.drive = drive[17:0];
    r.outer = outer[16:0];
    return r;
  endfunction

  function automatic logic [15:0] rand_word();
    case ($urandom_range(0, 9))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'hFFFF;
      3:       return 16'h0000;
      4:       return 16'($signed($urandom_range(0, 512)) - 256);
      default: return 16'($urandom);
    endcase
  endfunction

  // result side: checks each beat, then sets the stall pattern
  always @(posedge clk_i) begin : result_check
    pitch_result_t got;
    pitch_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[34:0];
      if (pitch_result_q.size() == 0) begin
        $error("result beat with nothing pending: drive %0d outer_term %0d",
               $signed(got.drive), $signed(got.outer));
        fail_cnt++;
      end else begin
        want = pitch_result_q.pop_front();
        if (got.drive !== want.drive) begin
          $error("drive expected %0d got %0d", $signed(want.drive), $signed(got.drive));
          fail_cnt++;
        end
        if (got.outer !== want.outer) begin
          $error("outer_term expected %0d got %0d", $signed(want.outer), $signed(got.outer));
          fail_cnt++;
        end
      end
    end
    if (rx_always) begin
      ready_left = 0;
      m_axis_tready <= 1'b1;
    end else if (ready_left == 0) begin
      if (m_axis_tready) begin
        ready_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 140)
                                                 : $urandom_range(1, stall_max);
        m_axis_tready <= 1'b0;
      end else begin
        ready_left = $urandom_range(1, 24);
        m_axis_tready <= 1'b1;
      end
    end else begin
      ready_left--;
    end
  end

  task automatic send_tick(input logic [15:0] tilt, input logic [15:0] drate,
                           input logic [15:0] rerr, input logic fb);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {rerr, drate, tilt};
    s_axis_tuser  <= fb;
    do @(posedge clk_i); while (!s_axis_tready);
    pitch_result_q.push_back(predict_pitch_tick(tilt, drate, rerr, fb));
  endtask

  task automatic wait_results;
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (pitch_result_q.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_OUTER_GAIN:   gain_outer_m = val;
      REG_FF_GAIN:      gain_ff_m    = val;
      REG_RATE_GAIN:    gain_rate_m  = val;
      REG_LEAD_GAIN:    gain_lead_m  = val;
      REG_STAB_ENABLE:  stab_en_m    = val[0];
      REG_LOADING_TRIM: trim_m       = val;
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_all_regs(input logic [15:0] og, input logic [15:0] ff,
                              input logic [15:0] rg, input logic [15:0] lg,
                              input logic [15:0] en, input logic [15:0] tr);
    wait_results;
    write_reg(REG_OUTER_GAIN, og);
    write_reg(REG_FF_GAIN, ff);
    write_reg(REG_RATE_GAIN, rg);
    write_reg(REG_LEAD_GAIN, lg);
    write_reg(REG_STAB_ENABLE, en);
    write_reg(REG_LOADING_TRIM, tr);
  endtask

  // reset gains are zero, so every term must come out as zero
  task automatic test_reset_values;
    send_tick(16'h7FFF, 16'h8000, 16'h7FFF, 1'b1);
    send_tick(16'h8000, 16'h7FFF, 16'h8000, 1'b1);
    send_tick(16'h1234, 16'hFEDC, 16'h0F0F, 1'b0);
  endtask

  task automatic test_field_extremes;
    set_all_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0001, 16'h7FFF);
    send_tick(16'h7FFF, 16'h8000, 16'h7FFF, 1'b1);
    send_tick(16'h8000, 16'h7FFF, 16'h8000, 1'b1);
    send_tick(16'h8000, 16'h8000, 16'h8000, 1'b1);
    send_tick(16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1);
    send_tick(16'h0000, 16'h0000, 16'h0000, 1'b1);
    send_tick(16'hFFFF, 16'h0001, 16'hFFFF, 1'b1);
    send_tick(16'h7FFF, 16'h8000, 16'h7FFF, 1'b0);
    set_all_regs(16'h0001, 16'h8000, 16'h0001, 16'h8000, 16'h0001, 16'h8000);
    send_tick(16'h8000, 16'h7FFF, 16'h8000, 1'b1);
    send_tick(16'h7FFF, 16'h8000, 16'h7FFF, 1'b1);
  endtask

  // enable written with its upper bits set, only bit zero counts
  task automatic test_outer_disabled;
    wait_results;
    write_reg(REG_STAB_ENABLE, 16'hFFFE);
    send_tick(16'h7FFF, 16'h8000, 16'h4000, 1'b1);
    send_tick(16'h8000, 16'h7FFF, 16'hC000, 1'b1);
    wait_results;
    write_reg(REG_STAB_ENABLE, 16'h0003);
    send_tick(16'h7FFF, 16'h8000, 16'h7FFF, 1'b0);
    send_tick(16'h8000, 16'h7FFF, 16'h8000, 1'b0);
  endtask

  task automatic test_unused_index;
    wait_results;
    write_reg(CFG_SPARE_LO, 16'hFFFF);
    write_reg(CFG_SPARE_HI, 16'h1234);
    send_tick(16'h4000, 16'hC000, 16'h2000, 1'b1);
    send_tick(16'hC000, 16'h4000, 16'hE000, 1'b1);
  endtask

  task automatic test_random_ticks;
    logic [15:0] tilt;
    logic [15:0] drate;
    logic [15:0] rerr;
    rerr = '0;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        1:       set_all_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0001, 16'h8000);
        2:       set_all_regs(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h7FFF);
        default: set_all_regs(rand_word(), rand_word(), rand_word(), rand_word(),
                              16'($urandom), rand_word());
      endcase
      case (p % 3)
        0: begin
          gap_max   = 0;
          rx_always = 1'b1;
        end
        1: begin
          gap_max   = 8;
          stall_max = 6;
          rx_always = 1'b0;
        end
        default: begin
          gap_max   = 110;
          stall_max = 40;
          rx_always = 1'b0;
        end
      endcase
      for (int n = 0; n < TICKS_PER_PHASE; n++) begin
        tilt  = rand_word();
        drate = rand_word();
        // rate error often held so the lead filter sees steps
        if ($urandom_range(0, 2) != 0) rerr = rand_word();
        send_tick(tilt, drate, rerr, $urandom_range(0, 4) != 0);
      end
    end
  endtask

  initial begin
    repeat (RST_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_values;
    test_field_extremes;
    test_outer_disabled;
    test_unused_index;
    test_random_ticks;
    wait_results;
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
